### rtl/ubr_pkg.sv
// package for the uart bit receiver: result kinds, queue entry layout, sizes
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ubr_pkg;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_INVALID = 2'd1,
        KIND_BREAK   = 2'd2
    } kind_t;

    localparam logic [7:0] BRK_MIN_RESET = 8'd32;
    localparam logic [7:0] ZERO_RUN_MAX  = 8'd255;

    // power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    // one bit's worth of results: optional break, then optional main result
    typedef struct packed {
        logic       has_brk;
        logic       has_main;
        kind_t      main_kind;
        logic [7:0] main_char;
    } entry_t;

endpackage

### rtl/ubr_front.sv
// front end: frame state machine, zero run counter and break threshold register
// depends on ubr_pkg; classifies each line bit into a queue entry
`timescale 1ns / 1ps

module ubr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            line_bit,
    input  logic            line_error,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_data,
    input  logic            q_full,
    output logic            q_push,
    output ubr_pkg::entry_t q_entry
);
    import ubr_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_DATA   = 6'b000010,
        PH_PARITY = 6'b000100,
        PH_STOP   = 6'b001000,
        PH_BREAK  = 6'b010000,
        PH_WAIT1  = 6'b100000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] data_reg, data_next;
    logic       parity_reg, parity_next;
    logic [7:0] zero_run_reg, zero_run_next;
    logic [7:0] brk_min_reg;

    logic   accept;
    logic   err, one, zero, long_run;
    entry_t ent;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    assign err      = line_error;
    assign one      = !line_error && line_bit;
    assign zero     = !line_error && !line_bit;
    assign long_run = zero_run_reg > brk_min_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        data_next    = data_reg;
        parity_next  = parity_reg;
        ent          = '{has_brk: 1'b0, has_main: 1'b0, main_kind: KIND_INVALID,
                         main_char: 8'd0};
        case (phase_reg)
            PH_IDLE:
            begin
                if (err)
                begin
                    ent.has_main = 1'b1;
                    phase_next   = PH_WAIT1;
                end
                else if (zero)
                begin
                    data_next    = 8'd0;
                    parity_next  = 1'b0;
                    bit_cnt_next = 3'd0;
                    phase_next   = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (err)
                begin
                    ent.has_main = 1'b1;
                    phase_next   = PH_WAIT1;
                end
                else
                begin
                    // lsb first: shift in at the top
                    data_next    = {one, data_reg[7:1]};
                    parity_next  = parity_reg ^ one;
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == 3'd7)
                    begin
                        phase_next = PH_PARITY;
                    end
                end
            end
            PH_PARITY:
            begin
                if (err)
                begin
                    ent.has_main = 1'b1;
                    phase_next   = PH_WAIT1;
                end
                else
                begin
                    parity_next = parity_reg ^ one;
                    phase_next  = PH_STOP;
                end
            end
            PH_STOP:
            begin
                if (err)
                begin
                    ent.has_main = 1'b1;
                    phase_next   = PH_WAIT1;
                end
                else if (zero)
                begin
                    phase_next = PH_BREAK;
                end
                else
                begin
                    ent.has_main = 1'b1;
                    if (!parity_reg)
                    begin
                        ent.main_kind = KIND_CHAR;
                        ent.main_char = data_reg;
                    end
                    phase_next = PH_IDLE;
                end
            end
            PH_BREAK:
            begin
                if (!zero)
                begin
                    ent.has_brk = long_run;
                    if (err)
                    begin
                        ent.has_main = 1'b1;
                        phase_next   = PH_WAIT1;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                // wait for a one; errors are swallowed here
                if (one)
                begin
                    ent.has_brk = long_run;
                    phase_next  = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_WAIT1;
                end
            end
        endcase

        if (zero)
        begin
            zero_run_next = (zero_run_reg == ZERO_RUN_MAX) ? zero_run_reg
                                                           : zero_run_reg + 8'd1;
        end
        else
        begin
            zero_run_next = 8'd0;
        end
    end

    assign q_entry = ent;
    assign q_push  = accept && (ent.has_brk || ent.has_main);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            bit_cnt_reg  <= 3'd0;
            data_reg     <= 8'd0;
            parity_reg   <= 1'b0;
            zero_run_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            data_reg     <= data_next;
            parity_reg   <= parity_next;
            zero_run_reg <= zero_run_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brk_min_reg <= BRK_MIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            brk_min_reg <= cfg_data;
        end
    end

    // a frame only leaves the data phase after all eight bits
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_DATA && !err && bit_cnt_reg != 3'd7)
        |=> phase_reg == PH_DATA)
        else $error("data phase left early");

    // a break result only follows a run of zeros
    a_brk_run: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_entry.has_brk) |-> zero_run_reg != 8'd0)
        else $error("break without a zero run");

endmodule

### rtl/ubr_queue.sv
// short queue of classified entries between front and back
// depends on ubr_pkg for the entry type and depth
`timescale 1ns / 1ps

module ubr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ubr_pkg::entry_t push_entry,
    input  logic            pop,
    output ubr_pkg::entry_t head,
    output logic            full,
    output logic            empty
);
    import ubr_pkg::*;

    entry_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue underflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

### rtl/ubr_back.sv
// back end: expands queue entries into one or two result transfers
// depends on ubr_pkg; holds the output register
`timescale 1ns / 1ps

module ubr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ubr_pkg::entry_t head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      result_kind,
    output logic [7:0]      char_value,
    output logic            last_of_run
);
    import ubr_pkg::*;

    logic       out_valid_reg;
    kind_t      kind_reg, kind_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       second_reg, second_next;
    logic       load;

    // output register is free when empty or being drained this cycle
    assign load = !empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        kind_next   = kind_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        second_next = second_reg;
        pop         = 1'b0;
        if (load)
        begin
            if (head.has_brk && !second_reg)
            begin
                kind_next   = KIND_BREAK;
                char_next   = 8'd0;
                last_next   = !head.has_main;
                pop         = !head.has_main;
                second_next = head.has_main;
            end
            else
            begin
                kind_next   = head.main_kind;
                char_next   = head.main_char;
                last_next   = 1'b1;
                pop         = 1'b1;
                second_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign char_value  = char_reg;
    assign last_of_run = last_reg;

    // the second half of a split entry stays at the queue head
    a_second_held: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> !empty)
        else $error("split entry lost from queue");

    // a break half that is not last must be followed by its main result
    a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !pop) |=> second_reg)
        else $error("split entry not tracked");

endmodule

### rtl/uart_bit_receiver_even_parity_top.sv
// top level of the uart 8e1 bit receiver with break detection
// depends on ubr_pkg, ubr_front, ubr_queue and ubr_back
//
//   channel   signals                                   direction
//   in        in_valid, in_ready, line_bit, line_error   sink
//   out       out_valid, out_ready, result_kind,         source
//             char_value, last_of_run
//   cfg       cfg_valid, cfg_ready, cfg_data             sink (break_min_zeroes)
//
// one line bit is taken per cycle while the queue is not full; the frame state
// machine in the front decides everything in the cycle of the transfer, so the
// input rate is one bit a cycle; a bit that causes results is written into the
// queue and then loaded into the output register; a bit causing break plus
// invalid needs two output transfers, as the single output register drains
// one result per cycle while out_ready is high; the two-entry queue lets the
// front take bits while the back stalls; bits with no result never enter it
// reset clears frame state, zero run, queue and output valid; threshold is 32
// cfg_ready is always high
`timescale 1ns / 1ps

module uart_bit_receiver_even_parity_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       line_bit,
    input  logic       line_error,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] char_value,
    output logic       last_of_run,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import ubr_pkg::*;

    // front to queue
    logic   q_push;
    entry_t q_entry;
    logic   q_full;

    // queue to back
    entry_t q_head;
    logic   q_empty;
    logic   q_pop;

    ubr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .line_bit   (line_bit),
        .line_error (line_error),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    // decouples bit classification from result delivery
    ubr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // splits break plus invalid entries into two transfers
    ubr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .empty       (q_empty),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .char_value  (char_value),
        .last_of_run (last_of_run)
    );

endmodule
